/* rtl/core/scaled_sine_screen_halftone_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the scaled sine-screen halftone
// Concurrent assertion forms used by the datapath; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SCALED_SINE_SCREEN_HALFTONE_TOP_ASSERT_SVH
`define SCALED_SINE_SCREEN_HALFTONE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSSH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SSSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSSH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SSSH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/sssh_pkg.sv */
// ----------------------------------------------------------------------------
// Scaled sine-screen halftone package
// Field widths, codes and the command and status bundles shared by the block.
// ----------------------------------------------------------------------------
package sssh_pkg;

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 9;
  localparam int PIX_W  = 8;
  localparam int SRC_W  = 10;
  localparam int DST_W  = 11;
  localparam int PER_W  = 5;
  localparam int PROD_W = IDX_W + SRC_W;
  localparam int DIV_W  = DST_W;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic signed [VAL_W:0] THRESHOLD = 10'sd127;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_PIXEL = 2'd0,
    ACT_LOAD_MOD   = 2'd1,
    ACT_RENDER     = 2'd2
  } sssh_action_t;

  typedef enum logic [2:0] {
    REG_SRC_ROWS = 3'd0,
    REG_SRC_COLS = 3'd1,
    REG_DST_ROWS = 3'd2,
    REG_DST_COLS = 3'd3,
    REG_PERIOD   = 3'd4
  } sssh_reg_t;

  typedef enum logic [1:0] {
    STEP_ROW  = 2'd0,
    STEP_COL  = 2'd1,
    STEP_TROW = 2'd2,
    STEP_TCOL = 2'd3
  } sssh_step_t;

  typedef struct packed {
    logic [SRC_W-1:0] src_rows;
    logic [SRC_W-1:0] src_cols;
    logic [DST_W-1:0] dst_rows;
    logic [DST_W-1:0] dst_cols;
    logic [PER_W-1:0] period;
  } sssh_cfg_t;

  typedef struct packed {
    logic       capture;
    logic       write;
    logic       mul;
    logic       div_start;
    logic       div_store;
    logic       read;
    logic       emit;
    sssh_step_t step;
  } sssh_cmd_t;

  typedef struct packed {
    logic load_img;
    logic load_mod;
    logic render;
    logic div_done;
    logic out_free;
  } sssh_status_t;

endpackage

/* rtl/core/sssh_in_if.sv */
// ----------------------------------------------------------------------------
// Input request channel
// Valid/ready channel carrying one load or render request.
// ----------------------------------------------------------------------------
interface sssh_in_if
  import sssh_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] load_value;

  modport source (output valid, output action, output row_index, output col_index,
                  output load_value, input ready);
  modport sink (input valid, input action, input row_index, input col_index,
                input load_value, output ready);
endinterface

/* rtl/core/sssh_out_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one halftone output bit.
// ----------------------------------------------------------------------------
interface sssh_out_if;
  logic valid;
  logic ready;
  logic out_bit;

  modport source (output valid, output out_bit, input ready);
  modport sink (input valid, input out_bit, output ready);
endinterface

/* rtl/core/scaled_sine_screen_halftone_top.sv */
// ----------------------------------------------------------------------------
// Scaled sine-screen halftone
// A request loads one grey image pixel, loads one modulation table entry or
// renders one output pixel. A render scales the output position back to the
// stored image by exact integer nearest-neighbour mapping, adds the table
// entry selected by the position plus one modulo the period, and returns 1
// when the sum is at most 127. Loads and ignored requests give no result.
// A load returns to idle after its memory write; a render uses the shared
// bit-serial divider, which runs four divisions of 20 steps each (two
// scaling quotients and two period remainders). A finished result waits
// in an output register while the next request is accepted. The memories
// need no clearing after reset.
// ----------------------------------------------------------------------------
module scaled_sine_screen_halftone_top
  import sssh_pkg::*;
#(
  parameter int MAX_SIDE     = 512,
  parameter int MAX_PERIOD   = 16,
  parameter int MAX_OUT_SIDE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  sssh_in_if.sink           in_ch,
  sssh_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  sssh_cfg_t    cfg;
  sssh_cmd_t    cmd;
  sssh_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic         out_bit;

  sssh_cfg #(
    .MAX_SIDE     (MAX_SIDE),
    .MAX_PERIOD   (MAX_PERIOD),
    .MAX_OUT_SIDE (MAX_OUT_SIDE)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sssh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sssh_datapath #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_PERIOD (MAX_PERIOD)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_ch.action),
    .in_row_index  (in_ch.row_index),
    .in_col_index  (in_ch.col_index),
    .in_load_value (in_ch.load_value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_valid),
    .out_bit       (out_bit),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.out_bit = out_bit;

endmodule

/* rtl/core/sssh_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the image, bitmap and period sizes, with
// the saturated values used by the datapath.
// ----------------------------------------------------------------------------
module sssh_cfg
  import sssh_pkg::*;
#(
  parameter int MAX_SIDE     = 512,
  parameter int MAX_PERIOD   = 16,
  parameter int MAX_OUT_SIDE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output sssh_cfg_t         cfg
);

  logic [SRC_W-1:0] src_rows_r;
  logic [SRC_W-1:0] src_cols_r;
  logic [DST_W-1:0] dst_rows_r;
  logic [DST_W-1:0] dst_cols_r;
  logic [PER_W-1:0] period_r;
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_rows_r <= SRC_W'(256);
      src_cols_r <= SRC_W'(256);
      dst_rows_r <= DST_W'(512);
      dst_cols_r <= DST_W'(512);
      period_r   <= PER_W'(5);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SRC_ROWS: src_rows_r <= cfg_pwdata[SRC_W-1:0];
        REG_SRC_COLS: src_cols_r <= cfg_pwdata[SRC_W-1:0];
        REG_DST_ROWS: dst_rows_r <= cfg_pwdata[DST_W-1:0];
        REG_DST_COLS: dst_cols_r <= cfg_pwdata[DST_W-1:0];
        REG_PERIOD:   period_r   <= cfg_pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_ROWS: cfg_prdata = CFG_DW'(src_rows_r);
      REG_SRC_COLS: cfg_prdata = CFG_DW'(src_cols_r);
      REG_DST_ROWS: cfg_prdata = CFG_DW'(dst_rows_r);
      REG_DST_COLS: cfg_prdata = CFG_DW'(dst_cols_r);
      REG_PERIOD:   cfg_prdata = CFG_DW'(period_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg.src_rows = src_rows_r;
    if (src_rows_r == '0) begin
      cfg.src_rows = SRC_W'(1);
    end else if (32'(src_rows_r) > MAX_SIDE) begin
      cfg.src_rows = SRC_W'(MAX_SIDE);
    end
    cfg.src_cols = src_cols_r;
    if (src_cols_r == '0) begin
      cfg.src_cols = SRC_W'(1);
    end else if (32'(src_cols_r) > MAX_SIDE) begin
      cfg.src_cols = SRC_W'(MAX_SIDE);
    end
    cfg.dst_rows = dst_rows_r;
    if (dst_rows_r == '0) begin
      cfg.dst_rows = DST_W'(1);
    end else if (32'(dst_rows_r) > MAX_OUT_SIDE) begin
      cfg.dst_rows = DST_W'(MAX_OUT_SIDE);
    end
    cfg.dst_cols = dst_cols_r;
    if (dst_cols_r == '0) begin
      cfg.dst_cols = DST_W'(1);
    end else if (32'(dst_cols_r) > MAX_OUT_SIDE) begin
      cfg.dst_cols = DST_W'(MAX_OUT_SIDE);
    end
    cfg.period = period_r;
    if (period_r == '0) begin
      cfg.period = PER_W'(1);
    end else if (32'(period_r) > MAX_PERIOD) begin
      cfg.period = PER_W'(MAX_PERIOD);
    end
  end

endmodule

/* rtl/core/sssh_div.sv */
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring divider producing one quotient bit per cycle, shared by the
// scaling and the period reductions.
// ----------------------------------------------------------------------------
module sssh_div
  import sssh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic [PROD_W-1:0] quotient,
  output logic [DIV_W-1:0]  remainder,
  output logic              done
);

  logic [PROD_W-1:0] quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_W:0]    rem_shift;
  logic [DIV_W:0]    rem_diff;
  logic              take;

  always_comb begin
    rem_shift = {rem_r, quo_r[PROD_W-1]};
    rem_diff  = rem_shift - {1'b0, dvsr_r};
    take      = rem_shift >= {1'b0, dvsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(PROD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[PROD_W-2:0], take};
      rem_r <= take ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

/* rtl/core/sssh_datapath.sv */
// ----------------------------------------------------------------------------
// Halftone datapath
// Request capture, image and modulation memories, scaling multiplier and
// divider, threshold compare and the result register.
// ----------------------------------------------------------------------------
`include "scaled_sine_screen_halftone_top_assert.svh"

module sssh_datapath
  import sssh_pkg::*;
#(
  parameter int MAX_SIDE   = 512,
  parameter int MAX_PERIOD = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ACT_W-1:0]        in_action,
  input  logic [IDX_W-1:0]        in_row_index,
  input  logic [IDX_W-1:0]        in_col_index,
  input  logic signed [VAL_W-1:0] in_load_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_bit,
  input  sssh_cfg_t               cfg,
  input  sssh_cmd_t               cmd,
  output sssh_status_t            status
);

  localparam int SIDE_W = $clog2(MAX_SIDE);
  localparam int P_W    = $clog2(MAX_PERIOD);
  localparam int IMG_AW = 2 * SIDE_W;
  localparam int MOD_AW = 2 * P_W;

  logic [PIX_W-1:0]        img_mem [0:(1 << IMG_AW)-1];
  logic [VAL_W-1:0]        mod_mem [0:(1 << MOD_AW)-1];

  logic [ACT_W-1:0]        act_r;
  logic [IDX_W-1:0]        row_r;
  logic [IDX_W-1:0]        col_r;
  logic [VAL_W-1:0]        val_r;
  logic [PROD_W-1:0]       prod_r;
  logic [SIDE_W-1:0]       ir_r;
  logic [SIDE_W-1:0]       ic_r;
  logic [P_W-1:0]          tr_r;
  logic [P_W-1:0]          tc_r;
  logic [PIX_W-1:0]        img_q_r;
  logic [VAL_W-1:0]        mod_q_r;
  logic                    out_valid_r;
  logic                    out_bit_r;

  logic [IDX_W-1:0]        mul_a;
  logic [SRC_W-1:0]        mul_b;
  logic [PROD_W-1:0]       div_dividend;
  logic [DIV_W-1:0]        div_divisor;
  logic [PROD_W-1:0]       div_quo;
  logic [DIV_W-1:0]        div_rem;
  logic                    div_done;
  logic [IDX_W:0]          next_idx;
  logic signed [VAL_W:0]   sum;
  logic                    img_in_range;
  logic                    mod_in_range;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      row_r <= in_row_index;
      col_r <= in_col_index;
      val_r <= in_load_value;
    end
  end

  always_comb begin
    img_in_range    = (32'(row_r) < MAX_SIDE) && (32'(col_r) < MAX_SIDE);
    mod_in_range    = (32'(row_r) < MAX_PERIOD) && (32'(col_r) < MAX_PERIOD);
    status.load_img = (act_r == ACT_LOAD_PIXEL) && img_in_range;
    status.load_mod = (act_r == ACT_LOAD_MOD) && mod_in_range;
    status.render   = (act_r == ACT_RENDER) && ({1'b0, row_r} < cfg.dst_rows) &&
                      ({1'b0, col_r} < cfg.dst_cols);
    status.div_done = div_done;
    status.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    mul_a        = row_r;
    mul_b        = cfg.src_rows;
    next_idx     = {1'b0, row_r} + (IDX_W + 1)'(1);
    div_dividend = prod_r;
    div_divisor  = cfg.dst_rows;
    unique case (cmd.step)
      STEP_ROW: begin
        mul_a       = row_r;
        mul_b       = cfg.src_rows;
        div_divisor = cfg.dst_rows;
      end
      STEP_COL: begin
        mul_a       = col_r;
        mul_b       = cfg.src_cols;
        div_divisor = cfg.dst_cols;
      end
      STEP_TROW: begin
        next_idx     = {1'b0, row_r} + (IDX_W + 1)'(1);
        div_dividend = PROD_W'(next_idx);
        div_divisor  = DIV_W'(cfg.period);
      end
      STEP_TCOL: begin
        next_idx     = {1'b0, col_r} + (IDX_W + 1)'(1);
        div_dividend = PROD_W'(next_idx);
        div_divisor  = DIV_W'(cfg.period);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  sssh_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.step)
        STEP_ROW:  ir_r <= SIDE_W'(div_quo);
        STEP_COL:  ic_r <= SIDE_W'(div_quo);
        STEP_TROW: tr_r <= P_W'(div_rem);
        STEP_TCOL: tc_r <= P_W'(div_rem);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && status.load_img) begin
      img_mem[{SIDE_W'(row_r), SIDE_W'(col_r)}] <= val_r[PIX_W-1:0];
    end
    if (cmd.read) begin
      img_q_r <= img_mem[{ir_r, ic_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && status.load_mod) begin
      mod_mem[{P_W'(row_r), P_W'(col_r)}] <= val_r;
    end
    if (cmd.read) begin
      mod_q_r <= mod_mem[{tr_r, tc_r}];
    end
  end

  assign sum = $signed({2'b00, img_q_r}) + $signed({mod_q_r[VAL_W-1], mod_q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bit_r <= (sum <= THRESHOLD);
    end
  end

  assign out_valid = out_valid_r;
  assign out_bit   = out_bit_r;

  `SSSH_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_r, "result not raised")
  `SSSH_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, status.out_free, "result overwritten")
  `SSSH_ASSERT_IMPL(a_write_load, clk, rst_n, cmd.write, status.load_img || status.load_mod, "write without load")
  `SSSH_ASSERT_IMPL(a_store_done, clk, rst_n, cmd.div_store, div_done, "store before divide done")
  `SSSH_ASSERT_NEXT(a_start_clr, clk, rst_n, cmd.div_start, !div_done, "divider done not cleared")

endmodule

/* rtl/core/sssh_ctrl.sv */
// ----------------------------------------------------------------------------
// Halftone controller
// Sequences request capture, memory writes, the two scaling divisions, the
// two period reductions, the memory read and the result hand-off.
// ----------------------------------------------------------------------------
module sssh_ctrl
  import sssh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sssh_status_t status,
  output sssh_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DSTART = 7'b0001000,
    S_DWAIT  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_RESULT = 7'b1000000
  } sssh_state_t;

  sssh_state_t state_r;
  sssh_state_t state_nxt;
  sssh_step_t  step_r;
  sssh_step_t  step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_ROW;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.load_img || status.load_mod) begin
          cmd.write = 1'b1;
          state_nxt = S_IDLE;
        end else if (status.render) begin
          step_nxt  = STEP_ROW;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          unique case (step_r)
            STEP_ROW: begin
              step_nxt  = STEP_COL;
              state_nxt = S_MUL;
            end
            STEP_COL: begin
              step_nxt  = STEP_TROW;
              state_nxt = S_DSTART;
            end
            STEP_TROW: begin
              step_nxt  = STEP_TCOL;
              state_nxt = S_DSTART;
            end
            STEP_TCOL: begin
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Testbench for the scaled sine-screen halftone
// Loads source pixels and modulation entries, renders output pixels under a
// range of size and period settings, and checks every returned bit against a
// behavioural prediction kept alongside the block. Both channels idle and
// stall at random; the configuration port is written only while idle.
// ----------------------------------------------------------------------------
module tb;
  import sssh_pkg::*;

  localparam int MAX_SIDE      = 512;
  localparam int MAX_PERIOD    = 16;
  localparam int MAX_OUT_SIDE  = 1024;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    hold;
  } halftone_req_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  sssh_in_if  in_ch ();
  sssh_out_if out_ch ();

  scaled_sine_screen_halftone_top #(
    .MAX_SIDE     (MAX_SIDE),
    .MAX_PERIOD   (MAX_PERIOD),
    .MAX_OUT_SIDE (MAX_OUT_SIDE)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  logic [SRC_W-1:0] cfg_src_rows = 10'd256;
  logic [SRC_W-1:0] cfg_src_cols = 10'd256;
  logic [DST_W-1:0] cfg_dst_rows = 11'd512;
  logic [DST_W-1:0] cfg_dst_cols = 11'd512;
  logic [PER_W-1:0] cfg_period   = 5'd5;

  logic [PIX_W-1:0]        pix_mem [MAX_SIDE*MAX_SIDE];
  logic signed [VAL_W-1:0] mod_mem [MAX_PERIOD*MAX_PERIOD];
  bit                      pix_known [MAX_SIDE*MAX_SIDE];
  bit                      mod_known [MAX_PERIOD*MAX_PERIOD];

  halftone_req_t pending_requests [$];
  bit            expected_bits [$];

  halftone_req_t in_flight;
  bit            sending;
  int unsigned   send_gap;
  int unsigned   send_calm;
  int unsigned   stall_left;
  int unsigned   stall_calm;
  int unsigned   idle_cycles;
  int unsigned   fail_count;
  logic          nxt_valid;
  logic          nxt_ready;
  bit            exp_bit;

  function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                           input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_cfg(input sssh_reg_t idx);
    case (idx)
      REG_SRC_ROWS: return clamp_to(cfg_src_rows, 1, MAX_SIDE);
      REG_SRC_COLS: return clamp_to(cfg_src_cols, 1, MAX_SIDE);
      REG_DST_ROWS: return clamp_to(cfg_dst_rows, 1, MAX_OUT_SIDE);
      REG_DST_COLS: return clamp_to(cfg_dst_cols, 1, MAX_OUT_SIDE);
      default:      return clamp_to(cfg_period, 1, MAX_PERIOD);
    endcase
  endfunction

  function automatic bit map_render(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                    output int unsigned img_addr,
                                    output int unsigned mod_addr);
    int unsigned dr;
    int unsigned dc;
    int unsigned p;
    dr = eff_cfg(REG_DST_ROWS);
    dc = eff_cfg(REG_DST_COLS);
    p  = eff_cfg(REG_PERIOD);
    img_addr = 0;
    mod_addr = 0;
    if (r >= dr || c >= dc) return 1'b0;
    img_addr = ((r * eff_cfg(REG_SRC_ROWS)) / dr) * MAX_SIDE
             + (c * eff_cfg(REG_SRC_COLS)) / dc;
    mod_addr = ((r + 1) % p) * MAX_PERIOD + (c + 1) % p;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int unsigned limit);
    if ($urandom_range(0, 99) < 90) return IDX_W'($urandom_range(0, limit - 1));
    return IDX_W'($urandom_range(0, 1023));
  endfunction

  task automatic predict_halftone(input halftone_req_t q);
    int unsigned ia;
    int unsigned ma;
    int          sum;
    case (q.action)
      ACT_LOAD_PIXEL: begin
        if (q.row < MAX_SIDE && q.col < MAX_SIDE) begin
          pix_mem[q.row * MAX_SIDE + q.col] = q.value[PIX_W-1:0];
        end
      end
      ACT_LOAD_MOD: begin
        if (q.row < MAX_PERIOD && q.col < MAX_PERIOD) begin
          mod_mem[q.row * MAX_PERIOD + q.col] = q.value;
        end
      end
      ACT_RENDER: begin
        if (map_render(q.row, q.col, ia, ma)) begin
          sum = int'(pix_mem[ia]) + int'(mod_mem[ma]);
          expected_bits.push_back(sum <= int'(THRESHOLD));
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_request(input logic [ACT_W-1:0] action, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v,
                              input bit hold);
    halftone_req_t q;
    q.action = action;
    q.row    = r;
    q.col    = c;
    q.value  = v;
    q.hold   = hold;
    pending_requests.push_back(q);
  endtask

  task automatic add_pixel_load(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                input logic signed [VAL_W-1:0] v, input bit hold);
    if (r < MAX_SIDE && c < MAX_SIDE) pix_known[r * MAX_SIDE + c] = 1'b1;
    push_request(ACT_LOAD_PIXEL, r, c, v, hold);
  endtask

  task automatic add_mod_load(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                              input logic signed [VAL_W-1:0] v, input bit hold);
    if (r < MAX_PERIOD && c < MAX_PERIOD) mod_known[r * MAX_PERIOD + c] = 1'b1;
    push_request(ACT_LOAD_MOD, r, c, v, hold);
  endtask

  // A render never reads an entry that has not been loaded: missing ones are
  // loaded with random content just ahead of it.
  task automatic add_render(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                            input bit hold);
    int unsigned ia;
    int unsigned ma;
    if (map_render(r, c, ia, ma)) begin
      if (!pix_known[ia]) begin
        add_pixel_load(IDX_W'(ia / MAX_SIDE), IDX_W'(ia % MAX_SIDE),
                       VAL_W'($urandom_range(0, 511)), 1'b0);
      end
      if (!mod_known[ma]) begin
        add_mod_load(IDX_W'(ma / MAX_PERIOD), IDX_W'(ma % MAX_PERIOD),
                     VAL_W'($urandom_range(0, 511)), 1'b0);
      end
    end
    push_request(ACT_RENDER, r, c, VAL_W'($urandom_range(0, 511)), hold);
  endtask

  task automatic run_random_phase(input int n);
    int unsigned sel;
    bit          hold;
    for (int i = 0; i < n; i++) begin
      hold = (i == 10) || ($urandom_range(0, 49) == 0);
      sel  = $urandom_range(0, 99);
      if (sel < 45) begin
        add_render(pick_index(eff_cfg(REG_DST_ROWS)), pick_index(eff_cfg(REG_DST_COLS)), hold);
      end else if (sel < 70) begin
        add_pixel_load(pick_index(eff_cfg(REG_SRC_ROWS)), pick_index(eff_cfg(REG_SRC_COLS)),
                       VAL_W'($urandom_range(0, 511)), hold);
      end else if (sel < 90) begin
        add_mod_load(pick_index(eff_cfg(REG_PERIOD)), pick_index(eff_cfg(REG_PERIOD)),
                     VAL_W'($urandom_range(0, 511)), hold);
      end else if (sel < 95) begin
        push_request(ACT_UNUSED, IDX_W'($urandom_range(0, 1023)),
                     IDX_W'($urandom_range(0, 1023)), VAL_W'($urandom_range(0, 511)), hold);
      end else begin
        add_render(IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)), hold);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || sending || expected_bits.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input sssh_reg_t idx, input int unsigned val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(int'(idx) * 4);
    cfg_pwdata  <= CFG_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SRC_ROWS: cfg_src_rows = SRC_W'(val);
      REG_SRC_COLS: cfg_src_cols = SRC_W'(val);
      REG_DST_ROWS: cfg_dst_rows = DST_W'(val);
      REG_DST_COLS: cfg_dst_cols = DST_W'(val);
      default:      cfg_period   = PER_W'(val);
    endcase
  endtask

  task automatic apply_config(input int unsigned sr, input int unsigned sc,
                              input int unsigned dr, input int unsigned dc,
                              input int unsigned p);
    wait_idle();
    write_reg(REG_SRC_ROWS, sr);
    write_reg(REG_SRC_COLS, sc);
    write_reg(REG_DST_ROWS, dr);
    write_reg(REG_DST_COLS, dc);
    write_reg(REG_PERIOD, p);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      sending     = 1'b0;
      send_gap    = 0;
    end else begin
      nxt_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predict_halftone(in_flight);
        nxt_valid = 1'b0;
        sending   = 1'b0;
        send_gap  = pick_gap(send_calm);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].hold && expected_bits.size() != 0)) begin
          in_flight = pending_requests.pop_front();
          sending   = 1'b1;
          nxt_valid = 1'b1;
          in_ch.action     <= in_flight.action;
          in_ch.row_index  <= in_flight.row;
          in_ch.col_index  <= in_flight.col;
          in_ch.load_value <= in_flight.value;
        end
      end
      in_ch.valid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bits.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("result with no render pending: out_bit %0b", out_ch.out_bit);
          end
          fail_count++;
        end else begin
          exp_bit = expected_bits.pop_front();
          if (out_ch.out_bit !== exp_bit) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("out_bit mismatch: expected %0b, got %0b", exp_bit, out_ch.out_bit);
            end
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
        if ($urandom_range(0, 99) < 10) stall_left = pick_gap(stall_calm);
      end
      out_ch.ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("scaled_sine_screen_halftone_top test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_LOAD_PIXEL;
    in_ch.row_index  = '0;
    in_ch.col_index  = '0;
    in_ch.load_value = '0;
    out_ch.ready     = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    fail_count       = 0;
    send_calm        = 0;
    stall_calm       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset settings.
    add_pixel_load(0, 0, 0, 1'b0);
    add_pixel_load(511, 511, 255, 1'b0);
    add_pixel_load(1, 1, -1, 1'b0);
    add_pixel_load(1023, 3, 7, 1'b0);
    add_pixel_load(4, 1023, 9, 1'b0);
    add_mod_load(1, 1, -256, 1'b0);
    add_mod_load(0, 0, 255, 1'b0);
    add_mod_load(15, 15, 0, 1'b0);
    add_mod_load(16, 2, 5, 1'b0);
    add_mod_load(3, 1023, -5, 1'b0);
    add_render(0, 0, 1'b0);
    add_render(2, 2, 1'b0);
    add_render(511, 511, 1'b0);
    add_render(4, 4, 1'b0);
    add_pixel_load(10, 10, 127, 1'b0);
    add_mod_load(1, 2, 0, 1'b0);
    add_render(20, 21, 1'b0);
    add_pixel_load(10, 11, 128, 1'b0);
    add_mod_load(1, 3, 0, 1'b0);
    add_render(20, 22, 1'b1);
    add_render(512, 0, 1'b0);
    add_render(0, 512, 1'b0);
    add_render(1023, 1023, 1'b0);
    push_request(ACT_UNUSED, 1023, 1023, -256, 1'b0);
    push_request(ACT_UNUSED, 0, 0, 0, 1'b0);

    apply_config(1, 1, 1, 1, 1);
    run_random_phase(50);
    apply_config(512, 512, 1024, 1024, 16);
    run_random_phase(90);
    apply_config(0, 1023, 2047, 0, 31);
    run_random_phase(60);
    apply_config(1023, 0, 0, 2047, 0);
    run_random_phase(60);
    apply_config(300, 7, 5, 900, 3);
    run_random_phase(50);
    repeat (5) begin
      apply_config($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 48),
                   $urandom_range(1, 48), $urandom_range(1, 16));
      run_random_phase(68);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("scaled_sine_screen_halftone_top test passed");
    end else begin
      $display("scaled_sine_screen_halftone_top test failed");
    end
    $finish;
  end

endmodule
